// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// File: rtl/rtpx_pkg.sv
// Package: shared types and constants of the range to prefix expander.
`timescale 1ns / 1ps

package rtpx_pkg;

   localparam int FIELD_WIDTH = 32;
   localparam int INDEX_WIDTH = 6;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_EMPTY    = 2'd1,
      STATUS_END_ONES = 2'd2,
      STATUS_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_RUN
   } back_state_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_flags_type;

endpackage

// File: rtl/rtpx_front.sv
// Front end: takes range words, classifies them and precomputes run seeds.
`timescale 1ns / 1ps

module rtpx_front #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [rtpx_pkg::FIELD_WIDTH-1:0]      req_range_start,
   input  logic [rtpx_pkg::FIELD_WIDTH-1:0]      req_range_end,
   input  rtpx_pkg::queue_flags_type             flags,
   output logic                                  push,
   output logic [4*VALUE_WIDTH+2:0]              push_word
);

   localparam int QW = 4 * VALUE_WIDTH + 3;

   logic [VALUE_WIDTH-1:0]  lo;
   logic [VALUE_WIDTH-1:0]  hi;
   logic [VALUE_WIDTH-1:0]  cp1;
   logic [VALUE_WIDTH:0]    span;
   rtpx_pkg::status_type    kind;
   logic                    accept;

   logic                    valid_ff;
   logic                    valid_in;
   logic [QW-1:0]           word_ff;
   logic [QW-1:0]           word_in;

   assign lo = VALUE_WIDTH'(req_range_start);
   assign hi = VALUE_WIDTH'(req_range_end);

   always_comb begin
      kind = rtpx_pkg::STATUS_OK;
      if ((&hi) && (lo != '0)) begin
         kind = rtpx_pkg::STATUS_END_ONES;
      end else if (lo > hi) begin
         kind = rtpx_pkg::STATUS_EMPTY;
      end
   end

   // cursor + 1 and block budget (cursor - start + 1), one bit wider
   assign cp1  = hi + VALUE_WIDTH'(1);
   assign span = {1'b0, hi} - {1'b0, lo} + (VALUE_WIDTH+1)'(1);

   assign busy   = valid_ff && flags.full;
   assign accept = start && !busy;
   assign push   = valid_ff && !flags.full;

   always_comb begin
      word_in  = accept ? {kind, lo, hi, cp1, span} : word_ff;
      valid_in = accept || (valid_ff && flags.full);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign push_word = word_ff;

endmodule

// File: rtl/rtpx_queue.sv
// Two-word queue between the front end and the expansion engine.
`timescale 1ns / 1ps

module rtpx_queue #(
   parameter int WIDTH = 131
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_word,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_word,
   output rtpx_pkg::queue_flags_type  flags
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]  slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

   assign pop_word    = slot_ff[rd_ptr_ff];
   assign flags.full  = (count_ff == CNT_W'(DEPTH));
   assign flags.empty = (count_ff == '0);

endmodule

// File: rtl/rtpx_back.sv
// Expansion engine: walks the range downward, one ternary entry per cycle.
`timescale 1ns / 1ps

module rtpx_back #(
   parameter int VALUE_WIDTH = 32,
   parameter int MAX_ENTRIES = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [4*VALUE_WIDTH+2:0]              pop_word,
   input  rtpx_pkg::queue_flags_type             flags,
   output logic                                  pop,
   output logic                                  rsp_valid,
   output logic [rtpx_pkg::FIELD_WIDTH-1:0]      rsp_pattern,
   output logic [rtpx_pkg::FIELD_WIDTH-1:0]      rsp_care_mask,
   output logic [rtpx_pkg::INDEX_WIDTH-1:0]      rsp_entry_index,
   output logic                                  rsp_entry_valid,
   output logic [1:0]                            rsp_status,
   output logic                                  rsp_last
);

   localparam int VW = VALUE_WIDTH;
   localparam int QW = 4 * VW + 3;
   localparam int CW = $clog2(MAX_ENTRIES + 1);

   rtpx_pkg::status_type     w_status;
   logic [VW-1:0]            w_lo;
   logic [VW-1:0]            w_cur;
   logic [VW-1:0]            w_cp1;
   logic [VW:0]              w_span;

   rtpx_pkg::back_state_type state_ff, state_in;
   logic [VW-1:0]            cur_ff, cur_in;
   logic [VW-1:0]            cp1_ff, cp1_in;
   logic [VW:0]              span_ff, span_in;
   logic [VW-1:0]            lo_ff, lo_in;
   logic [CW-1:0]            count_ff, count_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [rtpx_pkg::FIELD_WIDTH-1:0] rsp_pattern_ff, rsp_pattern_in;
   logic [rtpx_pkg::FIELD_WIDTH-1:0] rsp_mask_ff, rsp_mask_in;
   logic [rtpx_pkg::INDEX_WIDTH-1:0] rsp_index_ff, rsp_index_in;
   logic                     rsp_entry_ff, rsp_entry_in;
   rtpx_pkg::status_type     rsp_status_ff, rsp_status_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic [VW:0]              smear;
   logic [VW-1:0]            ones_run;
   logic [VW-1:0]            fit_mask;
   logic [VW-1:0]            blk_mask;
   logic [VW-1:0]            base;
   logic [VW-1:0]            next_cur;
   logic [VW:0]              next_span;
   logic                     is_last;
   logic [63:0]              base_wide;
   logic [63:0]              mask_wide;

   assign w_status = rtpx_pkg::status_type'(pop_word[QW-1 -: 2]);
   assign w_lo     = pop_word[4*VW : 3*VW+1];
   assign w_cur    = pop_word[3*VW : 2*VW+1];
   assign w_cp1    = pop_word[2*VW : VW+1];
   assign w_span   = pop_word[VW:0];

   // block = min(trailing ones of cursor, floor log2 of budget), both as low masks
   always_comb begin
      smear = span_ff;
      for (int sh = 1; sh <= VW; sh = sh * 2) begin
         smear = smear | (smear >> sh);
      end
   end

   assign ones_run  = cur_ff & ~cp1_ff;
   assign fit_mask  = smear[VW:1];
   assign blk_mask  = ones_run & fit_mask;
   assign base      = cur_ff & ~blk_mask;
   assign is_last   = (base == lo_ff);
   assign next_cur  = base - VW'(1);
   assign next_span = span_ff + {1'b1, ~blk_mask};
   assign base_wide = 64'(base);
   assign mask_wide = 64'(~blk_mask);

   always_comb begin
      state_in       = state_ff;
      cur_in         = cur_ff;
      cp1_in         = cp1_ff;
      span_in        = span_ff;
      lo_in          = lo_ff;
      count_in       = count_ff;
      pop            = 1'b0;
      rsp_valid_in   = 1'b0;
      rsp_pattern_in = rsp_pattern_ff;
      rsp_mask_in    = rsp_mask_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_entry_in   = rsp_entry_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_last_in    = rsp_last_ff;
      case (state_ff)
         rtpx_pkg::BACK_IDLE: begin
            if (!flags.empty) begin
               pop = 1'b1;
               if (w_status != rtpx_pkg::STATUS_OK) begin
                  rsp_valid_in   = 1'b1;
                  rsp_pattern_in = '0;
                  rsp_mask_in    = '0;
                  rsp_index_in   = '0;
                  rsp_entry_in   = 1'b0;
                  rsp_status_in  = w_status;
                  rsp_last_in    = 1'b1;
               end else begin
                  cur_in   = w_cur;
                  cp1_in   = w_cp1;
                  span_in  = w_span;
                  lo_in    = w_lo;
                  count_in = '0;
                  state_in = rtpx_pkg::BACK_RUN;
               end
            end
         end
         rtpx_pkg::BACK_RUN: begin
            rsp_valid_in = 1'b1;
            rsp_index_in = rtpx_pkg::INDEX_WIDTH'(count_ff);
            if (count_ff == CW'(MAX_ENTRIES)) begin
               rsp_pattern_in = '0;
               rsp_mask_in    = '0;
               rsp_entry_in   = 1'b0;
               rsp_status_in  = rtpx_pkg::STATUS_OVERFLOW;
               rsp_last_in    = 1'b1;
               state_in       = rtpx_pkg::BACK_IDLE;
            end else begin
               rsp_pattern_in = base_wide[rtpx_pkg::FIELD_WIDTH-1:0];
               rsp_mask_in    = mask_wide[rtpx_pkg::FIELD_WIDTH-1:0];
               rsp_entry_in   = 1'b1;
               rsp_status_in  = rtpx_pkg::STATUS_OK;
               rsp_last_in    = is_last;
               cur_in         = next_cur;
               cp1_in         = base;
               span_in        = next_span;
               count_in       = count_ff + CW'(1);
               if (is_last) begin
                  state_in = rtpx_pkg::BACK_IDLE;
               end
            end
         end
         default: begin
            state_in = rtpx_pkg::BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rtpx_pkg::BACK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff         <= cur_in;
      cp1_ff         <= cp1_in;
      span_ff        <= span_in;
      lo_ff          <= lo_in;
      count_ff       <= count_in;
      rsp_pattern_ff <= rsp_pattern_in;
      rsp_mask_ff    <= rsp_mask_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_entry_ff   <= rsp_entry_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pattern     = rsp_pattern_ff;
   assign rsp_care_mask   = rsp_mask_ff;
   assign rsp_entry_index = rsp_index_ff;
   assign rsp_entry_valid = rsp_entry_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// File: rtl/range_to_tcam_prefixes.sv
// Top level: range to ternary prefix expander (front end, queue, engine).
//
//  channel   direction  handshake                ports
//  request   in         start high, busy low     req_range_start, req_range_end
//  response  out        rsp_valid strobe, 1 cyc  rsp_pattern, rsp_care_mask,
//                                                rsp_entry_index, rsp_entry_valid,
//                                                rsp_status, rsp_last
//
// A request word is registered in the front end, then waits in the two-word
// queue. The engine pops it and issues one response word per cycle after that,
// and pops the next word only once the run is over; a status-only answer is a
// single word.
// busy rises only when the front-end register and the queue are both full.
// Reset is synchronous and clears the valid flags, queue pointers and engine
// state; the response side has no stall and sees every word once.
`timescale 1ns / 1ps

module range_to_tcam_prefixes #(
   parameter int MAX_ENTRIES = 32,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [rtpx_pkg::FIELD_WIDTH-1:0]      req_range_start,
   input  logic [rtpx_pkg::FIELD_WIDTH-1:0]      req_range_end,
   output logic                                  rsp_valid,
   output logic [rtpx_pkg::FIELD_WIDTH-1:0]      rsp_pattern,
   output logic [rtpx_pkg::FIELD_WIDTH-1:0]      rsp_care_mask,
   output logic [rtpx_pkg::INDEX_WIDTH-1:0]      rsp_entry_index,
   output logic                                  rsp_entry_valid,
   output logic [1:0]                            rsp_status,
   output logic                                  rsp_last
);

   // queue word: status, start, cursor, cursor + 1, budget (one bit wider)
   localparam int QW = 4 * VALUE_WIDTH + 3;

   logic                       push;
   logic [QW-1:0]              push_word;
   logic                       pop;
   logic [QW-1:0]              pop_word;
   rtpx_pkg::queue_flags_type  flags;

   // classification and seed arithmetic
   rtpx_front #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_range_start (req_range_start),
      .req_range_end   (req_range_end),
      .flags           (flags),
      .push            (push),
      .push_word       (push_word)
   );

   // decouples the front end from a long run in the engine
   rtpx_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .pop       (pop),
      .pop_word  (pop_word),
      .flags     (flags)
   );

   // one entry per cycle: trailing-ones mask ANDed with the budget mask
   rtpx_back #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_word        (pop_word),
      .flags           (flags),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_pattern     (rsp_pattern),
      .rsp_care_mask   (rsp_care_mask),
      .rsp_entry_index (rsp_entry_index),
      .rsp_entry_valid (rsp_entry_valid),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last)
   );

endmodule

// File: rtl/rtpx_checker.sv
// Port-level checker for the range to prefix expander, with its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rtpx_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  start,
   input logic                                  busy,
   input logic                                  rsp_valid,
   input logic [rtpx_pkg::FIELD_WIDTH-1:0]      rsp_pattern,
   input logic [rtpx_pkg::FIELD_WIDTH-1:0]      rsp_care_mask,
   input logic [rtpx_pkg::INDEX_WIDTH-1:0]      rsp_entry_index,
   input logic                                  rsp_entry_valid,
   input logic [1:0]                            rsp_status,
   input logic                                  rsp_last
);

   logic req_seen;
   assign req_seen = start && !busy;

   // entry words carry ok status and no pattern bits outside the mask
   `ASSERT_IMPLY(a_entry_shape, clock, reset, rsp_valid && rsp_entry_valid, rsp_status == rtpx_pkg::STATUS_OK && (rsp_pattern & ~rsp_care_mask) == '0)

   // status-only words close the run and are blank
   `ASSERT_IMPLY(a_status_word, clock, reset, rsp_valid && !rsp_entry_valid, rsp_last && rsp_pattern == '0 && rsp_care_mask == '0 && rsp_status != rtpx_pkg::STATUS_OK)

   // rejected ranges answer at index zero
   `ASSERT_IMPLY(a_reject_index, clock, reset, rsp_valid && (rsp_status == rtpx_pkg::STATUS_EMPTY || rsp_status == rtpx_pkg::STATUS_END_ONES), rsp_entry_index == '0 && !req_seen || rsp_entry_index == '0)

   // an open run continues in the next cycle with the next index
   `ASSERT_NEXT(a_run_step, clock, reset, rsp_valid && !rsp_last, rsp_valid && rsp_entry_index == $past(rsp_entry_index) + 6'd1)

endmodule

bind range_to_tcam_prefixes rtpx_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_pattern     (rsp_pattern),
   .rsp_care_mask   (rsp_care_mask),
   .rsp_entry_index (rsp_entry_index),
   .rsp_entry_valid (rsp_entry_valid),
   .rsp_status      (rsp_status),
   .rsp_last        (rsp_last)
);
